FILE: rtl/hvn_pkg.sv
// Heightmap vertex normal package: field widths, register indexes, operation codes
// and the read slot descriptor shared by the sequencer and the accumulator.
// No dependencies.
package hvn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 8;
  localparam int Y_W      = 24;
  localparam int POS_W    = 27;
  localparam int NRM_W    = 46;
  localparam int NY_W     = 32;
  localparam int SUM_W    = 30;

  localparam int MSIZE_W  = 9;
  localparam int TILE_W   = 16;
  localparam int HALF_W   = 26;
  localparam int SCALE_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 8'd3;

  localparam logic [MSIZE_W-1:0] RST_MAP_SIZE     = 9'd256;
  localparam logic [TILE_W-1:0]  RST_TILE_SIZE    = 16'd256;
  localparam logic [HALF_W-1:0]  RST_HALF_EXTENT  = 26'd32640;
  localparam logic [SCALE_W-1:0] RST_HEIGHT_SCALE = 16'd256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // One neighbour read: position in the 3x3 window around the queried vertex.
  typedef struct packed {
    logic       clear;
    logic       valid;
    logic       in_map;
    logic [1:0] gc;
    logic [1:0] gr;
  } slot_t;

endpackage

FILE: rtl/hvn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hvn_accum.sv
// Height scaling and normal accumulation over the 3x3 neighbour window.
// Depends on hvn_pkg; fed by the read data of hvn_ram.
module hvn_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  hvn_pkg::slot_t                    slot,
  input  logic [hvn_pkg::SAMPLE_W-1:0]      rdata,
  input  logic [hvn_pkg::SCALE_W-1:0]       scale,
  input  logic [3:0]                        quad_valid,
  output logic signed [hvn_pkg::SUM_W-1:0]  sum_x,
  output logic signed [hvn_pkg::SUM_W-1:0]  sum_z,
  output logic [hvn_pkg::Y_W-1:0]           center_y,
  output logic                              busy
);

  // Weight of a window vertex in the x sum: +1 per valid quad where it sits
  // in the left column, -1 where it sits in the right column.
  function automatic logic signed [2:0] coef_x(input logic [1:0] gc, input logic [1:0] gr,
                                               input logic [3:0] qv);
    logic signed [2:0] c;
    logic [1:0] qc;
    logic [1:0] qr;
    c = '0;
    for (int q = 0; q < 4; q++) begin
      qc = {1'b0, 1'(q)};
      qr = {1'b0, 1'(q >> 1)};
      if (qv[q] && (gc == qc || gc == qc + 2'd1) && (gr == qr || gr == qr + 2'd1)) begin
        c = (gc == qc) ? c + 3'sd1 : c - 3'sd1;
      end
    end
    return c;
  endfunction

  // Same for z: top row counts +1, bottom row -1.
  function automatic logic signed [2:0] coef_z(input logic [1:0] gc, input logic [1:0] gr,
                                               input logic [3:0] qv);
    logic signed [2:0] c;
    logic [1:0] qc;
    logic [1:0] qr;
    c = '0;
    for (int q = 0; q < 4; q++) begin
      qc = {1'b0, 1'(q)};
      qr = {1'b0, 1'(q >> 1)};
      if (qv[q] && (gc == qc || gc == qc + 2'd1) && (gr == qr || gr == qr + 2'd1)) begin
        c = (gr == qr) ? c + 3'sd1 : c - 3'sd1;
      end
    end
    return c;
  endfunction

  function automatic logic signed [hvn_pkg::SUM_W-1:0] weigh(input logic signed [2:0] c,
                                                           input logic [hvn_pkg::Y_W-1:0] y);
    logic signed [hvn_pkg::SUM_W-1:0] ys;
    logic signed [hvn_pkg::SUM_W-1:0] r;
    ys = $signed(hvn_pkg::SUM_W'(y));
    case (c)
      3'sd1:    r = ys;
      3'sd2:    r = ys <<< 1;
      -3'sd1:   r = -ys;
      -3'sd2:   r = -(ys <<< 1);
      default:  r = '0;
    endcase
    return r;
  endfunction

  logic                    tag_valid;
  logic                    tag_in_map;
  logic [1:0]              tag_gc;
  logic [1:0]              tag_gr;
  logic                    y_valid;
  logic [1:0]              y_gc;
  logic [1:0]              y_gr;
  logic [hvn_pkg::Y_W-1:0] y;
  logic [31:0]             prod;

  assign prod = 32'(rdata) * 32'(scale);
  assign busy = tag_valid | y_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
      y_valid   <= 1'b0;
    end else begin
      tag_valid <= slot.valid;
      y_valid   <= tag_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_in_map <= slot.in_map;
    tag_gc     <= slot.gc;
    tag_gr     <= slot.gr;
    y          <= tag_in_map ? prod[31:8] : '0;
    y_gc       <= tag_gc;
    y_gr       <= tag_gr;
    if (slot.clear) begin
      sum_x <= '0;
      sum_z <= '0;
    end else if (y_valid) begin
      sum_x <= sum_x + weigh(coef_x(y_gc, y_gr, quad_valid), y);
      sum_z <= sum_z + weigh(coef_z(y_gc, y_gr, quad_valid), y);
    end
    if (y_valid && y_gc == 2'd1 && y_gr == 2'd1) begin
      center_y <= y;
    end
  end

endmodule

FILE: rtl/heightmap_vertex_normal_core.sv
// Heightmap vertex normal core: height store, query sequencer and result register.
// Depends on hvn_pkg, hvn_ram and hvn_accum.
//
//  channel   direction  handshake               payload
//  item      in         item_valid/item_stall   func, col, row, height_sample
//  result    out        result_valid/result_stall pos_x..normal_z, range_error
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A write is stored in its item beat. A query inside the map passes its beat, nine
// neighbour reads from the single RAM read port (S_READ), a drain of the read,
// scaling and accumulation registers (S_DRAIN), the multiplies (S_MUL) and the
// result register load (S_FIN); a query off the map goes from its beat to S_FIN.
// Reset clears control state and the configuration registers, not the height store.
// A stalled result holds while writes and the next query are still taken in.
module heightmap_vertex_normal_core #(
  parameter int MAX_MAP_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  logic [hvn_pkg::IDX_W-1:0]           col,
  input  logic [hvn_pkg::IDX_W-1:0]           row,
  input  logic [hvn_pkg::SAMPLE_W-1:0]        height_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [hvn_pkg::POS_W-1:0]    pos_x,
  output logic [hvn_pkg::Y_W-1:0]             pos_y,
  output logic signed [hvn_pkg::POS_W-1:0]    pos_z,
  output logic signed [hvn_pkg::NRM_W-1:0]    normal_x,
  output logic [hvn_pkg::NY_W-1:0]            normal_y,
  output logic signed [hvn_pkg::NRM_W-1:0]    normal_z,
  output logic                                range_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAX_N = (MAX_MAP_SIZE > 511) ? 511 : MAX_MAP_SIZE;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DRAIN, S_MUL, S_FIN} state_t;

  state_t state;

  logic [hvn_pkg::MSIZE_W-1:0] side_count;
  logic [hvn_pkg::TILE_W-1:0]  tile;
  logic [hvn_pkg::HALF_W-1:0]  half;
  logic [hvn_pkg::SCALE_W-1:0] scale;

  logic [hvn_pkg::MSIZE_W-1:0] n_eff;
  logic                        item_beat;
  logic                        item_in_map;
  logic                        ram_we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [hvn_pkg::SAMPLE_W-1:0] rdata;

  logic [hvn_pkg::IDX_W-1:0]   col_q;
  logic [hvn_pkg::IDX_W-1:0]   row_q;
  logic [3:0]                  qv;
  logic                        err;
  logic [1:0]                  gc;
  logic [1:0]                  gr;
  logic [9:0]                  nc;
  logic [9:0]                  nr;
  logic                        n_in_map;

  hvn_pkg::slot_t              slot;
  logic signed [hvn_pkg::SUM_W-1:0] sum_x;
  logic signed [hvn_pkg::SUM_W-1:0] sum_z;
  logic [hvn_pkg::Y_W-1:0]     center_y;
  logic                        acc_busy;

  logic signed [hvn_pkg::NRM_W-1:0] prod_x;
  logic signed [hvn_pkg::NRM_W-1:0] prod_z;
  logic [hvn_pkg::Y_W-1:0]     px_m;
  logic [hvn_pkg::Y_W-1:0]     pz_m;
  logic [hvn_pkg::NY_W-1:0]    tt;
  logic [1:0]                  shamt;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_beat  = item_valid && !item_stall;

  assign n_eff = (side_count < 9'd2) ? 9'd2 :
                 (side_count > 9'(MAX_N)) ? 9'(MAX_N) : side_count;
  assign item_in_map = ({1'b0, col} < n_eff) && ({1'b0, row} < n_eff);

  assign ram_we = item_beat && func == hvn_pkg::FUNC_WRITE && item_in_map;
  assign waddr  = AW'(row) * AW'(MAX_MAP_SIZE) + AW'(col);

  assign nc = 10'(col_q) + 10'(gc) - 10'd1;
  assign nr = 10'(row_q) + 10'(gr) - 10'd1;
  assign n_in_map = !nc[9] && !nr[9] && (nc[8:0] < n_eff) && (nr[8:0] < n_eff);
  assign raddr = n_in_map ? AW'(nr[8:0]) * AW'(MAX_MAP_SIZE) + AW'(nc[8:0]) : '0;

  assign slot = {item_beat && func == hvn_pkg::FUNC_QUERY, state == S_READ, n_in_map,
                 gc, gr};

  always_ff @(posedge clk) begin
    if (rst) begin
      side_count <= hvn_pkg::RST_MAP_SIZE;
      tile       <= hvn_pkg::RST_TILE_SIZE;
      half       <= hvn_pkg::RST_HALF_EXTENT;
      scale      <= hvn_pkg::RST_HEIGHT_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hvn_pkg::CFG_MAP_SIZE:     side_count <= cfg_data[hvn_pkg::MSIZE_W-1:0];
        hvn_pkg::CFG_TILE_SIZE:    tile       <= cfg_data[hvn_pkg::TILE_W-1:0];
        hvn_pkg::CFG_HALF_EXTENT:  half       <= cfg_data[hvn_pkg::HALF_W-1:0];
        hvn_pkg::CFG_HEIGHT_SCALE: scale      <= cfg_data[hvn_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      gc           <= '0;
      gr           <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_beat && func == hvn_pkg::FUNC_QUERY) begin
            col_q <= col;
            row_q <= row;
            gc    <= '0;
            gr    <= '0;
            qv[0] <= (col != '0) && (row != '0);
            qv[1] <= ({1'b0, col} + 9'd1 < n_eff) && (row != '0);
            qv[2] <= (col != '0) && ({1'b0, row} + 9'd1 < n_eff);
            qv[3] <= ({1'b0, col} + 9'd1 < n_eff) && ({1'b0, row} + 9'd1 < n_eff);
            err   <= !item_in_map;
            state <= item_in_map ? S_READ : S_FIN;
          end
        end
        S_READ: begin
          if (gc == 2'd2) begin
            gc <= '0;
            if (gr == 2'd2) begin
              state <= S_DRAIN;
            end else begin
              gr <= gr + 2'd1;
            end
          end else begin
            gc <= gc + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!acc_busy) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= $signed({1'b0, tile}) * hvn_pkg::NRM_W'(sum_x);
          prod_z <= $signed({1'b0, tile}) * hvn_pkg::NRM_W'(sum_z);
          px_m   <= hvn_pkg::Y_W'(col_q) * hvn_pkg::Y_W'(tile);
          pz_m   <= hvn_pkg::Y_W'(row_q) * hvn_pkg::Y_W'(tile);
          tt     <= hvn_pkg::NY_W'(tile) * hvn_pkg::NY_W'(tile);
          shamt  <= ($countones(qv) == 1) ? 2'd1 : ($countones(qv) == 2) ? 2'd2 : 2'd3;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            range_error  <= err;
            if (err) begin
              pos_x    <= '0;
              pos_y    <= '0;
              pos_z    <= '0;
              normal_x <= '0;
              normal_y <= '0;
              normal_z <= '0;
            end else begin
              pos_x    <= $signed(hvn_pkg::POS_W'(px_m) - hvn_pkg::POS_W'(half));
              pos_y    <= center_y;
              pos_z    <= $signed(hvn_pkg::POS_W'(pz_m) - hvn_pkg::POS_W'(half));
              normal_x <= prod_x >>> shamt;
              normal_y <= tt;
              normal_z <= prod_z >>> shamt;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hvn_ram #(
    .WIDTH (hvn_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (height_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  hvn_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .slot       (slot),
    .rdata      (rdata),
    .scale      (scale),
    .quad_valid (qv),
    .sum_x      (sum_x),
    .sum_z      (sum_z),
    .center_y   (center_y),
    .busy       (acc_busy)
  );

  a_write_no_reads: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !acc_busy)
    else $error("height store written while neighbour reads in flight");

  a_mul_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> !acc_busy)
    else $error("normal multiply started before accumulation finished");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!result_valid || !result_stall)) |=> result_valid && state == S_IDLE)
    else $error("result beat not loaded");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && range_error) |-> (normal_y == '0 && pos_y == '0 && normal_x == '0))
    else $error("range error beat carries data");

endmodule

FILE: verif/tb_heightmap_vertex_normal_core.sv
// Self-checking testbench for heightmap_vertex_normal_core: directed steps, then random
// phases of height writes and vertex queries, checked against an in-bench vertex predictor.
// Depends on hvn_pkg and the core RTL.
module tb_heightmap_vertex_normal_core;

  localparam int HALF_PERIOD   = 10;
  localparam int MAP_MAX       = 256;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 83;
  localparam logic [hvn_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd9;

  typedef struct packed {
    logic signed [hvn_pkg::POS_W-1:0] px;
    logic [hvn_pkg::Y_W-1:0]          py;
    logic signed [hvn_pkg::POS_W-1:0] pz;
    logic signed [hvn_pkg::NRM_W-1:0] nx;
    logic [hvn_pkg::NY_W-1:0]         ny;
    logic signed [hvn_pkg::NRM_W-1:0] nz;
    logic                             err;
  } vertex_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t                     kind;
    logic                           fn;
    logic [hvn_pkg::IDX_W-1:0]      c;
    logic [hvn_pkg::IDX_W-1:0]      r;
    logic [hvn_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [hvn_pkg::CFG_DATA_W-1:0] value;
    logic                           typed;
    vertex_t                        want;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic func;
  logic [hvn_pkg::IDX_W-1:0] col;
  logic [hvn_pkg::IDX_W-1:0] row;
  logic [hvn_pkg::SAMPLE_W-1:0] height_sample;
  logic result_valid;
  logic result_stall;
  logic signed [hvn_pkg::POS_W-1:0] pos_x;
  logic [hvn_pkg::Y_W-1:0] pos_y;
  logic signed [hvn_pkg::POS_W-1:0] pos_z;
  logic signed [hvn_pkg::NRM_W-1:0] normal_x;
  logic [hvn_pkg::NY_W-1:0] normal_y;
  logic signed [hvn_pkg::NRM_W-1:0] normal_z;
  logic range_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [hvn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hvn_pkg::CFG_DATA_W-1:0] cfg_data;

  heightmap_vertex_normal_core #(.MAX_MAP_SIZE(MAP_MAX)) dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  logic [hvn_pkg::SAMPLE_W-1:0] heights [MAP_MAX*MAP_MAX];
  bit                           written [MAP_MAX*MAP_MAX];
  logic [hvn_pkg::MSIZE_W-1:0]  m_size  = hvn_pkg::RST_MAP_SIZE;
  logic [hvn_pkg::TILE_W-1:0]   m_tile  = hvn_pkg::RST_TILE_SIZE;
  logic [hvn_pkg::HALF_W-1:0]   m_half  = hvn_pkg::RST_HALF_EXTENT;
  logic [hvn_pkg::SCALE_W-1:0]  m_scale = hvn_pkg::RST_HEIGHT_SCALE;

  vertex_t pending_vertices[$];
  vertex_t seen_vertex;
  vertex_t due_vertex;
  step_t   directed_plan[$];

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int faults = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_off_map = 0;
  int n_results = 0;
  int n_reg_writes = 0;

  function automatic int active_side();
    int s;
    s = int'(m_size);
    if (s < 2) s = 2;
    if (s > MAP_MAX) s = MAP_MAX;
    return s;
  endfunction

  function automatic longint scaled_height(input int c, input int r);
    return (longint'(heights[r*MAP_MAX + c]) * longint'(m_scale)) >>> 8;
  endfunction

  function automatic bit heights_known(input int c, input int r);
    int n, dc, dr, cc, rr;
    n = active_side();
    if (c >= n || r >= n) return 1'b1;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        cc = c + dc;
        rr = r + dr;
        if (cc >= 0 && rr >= 0 && cc < n && rr < n && !written[rr*MAP_MAX + cc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic vertex_t predict_vertex(input int c, input int r);
    vertex_t v;
    int n, dq, qx, qy, quads, sh;
    longint t, sx, sz, ha, hb, hc, hd;
    v = '0;
    n = active_side();
    if (c >= n || r >= n) begin
      v.err = 1'b1;
      return v;
    end
    t = longint'(m_tile);
    sx = 0;
    sz = 0;
    quads = 0;
    for (dq = 0; dq < 4; dq++) begin
      qx = c - (dq & 1);
      qy = r - (dq >> 1);
      if (qx >= 0 && qy >= 0 && qx < n - 1 && qy < n - 1) begin
        ha = scaled_height(qx, qy);
        hb = scaled_height(qx, qy + 1);
        hc = scaled_height(qx + 1, qy);
        hd = scaled_height(qx + 1, qy + 1);
        sx += t * (ha - hc + hb - hd);
        sz += t * (ha - hb + hc - hd);
        quads++;
      end
    end
    sh = (quads == 1) ? 1 : (quads == 2) ? 2 : 3;
    v.px = hvn_pkg::POS_W'(c * t - longint'(m_half));
    v.py = hvn_pkg::Y_W'(scaled_height(c, r));
    v.pz = hvn_pkg::POS_W'(r * t - longint'(m_half));
    v.nx = hvn_pkg::NRM_W'(sx >>> sh);
    v.ny = hvn_pkg::NY_W'(t * t);
    v.nz = hvn_pkg::NRM_W'(sz >>> sh);
    return v;
  endfunction

  function automatic void store_sample(input int c, input int r,
                                       input logic [hvn_pkg::SAMPLE_W-1:0] s);
    int n;
    n = active_side();
    if (c < n && r < n) begin
      heights[r*MAP_MAX + c] = s;
      written[r*MAP_MAX + c] = 1'b1;
    end
  endfunction

  function automatic void apply_reg(input logic [hvn_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [hvn_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      hvn_pkg::CFG_MAP_SIZE:     m_size  = data[hvn_pkg::MSIZE_W-1:0];
      hvn_pkg::CFG_TILE_SIZE:    m_tile  = data[hvn_pkg::TILE_W-1:0];
      hvn_pkg::CFG_HALF_EXTENT:  m_half  = data[hvn_pkg::HALF_W-1:0];
      hvn_pkg::CFG_HEIGHT_SCALE: m_scale = data[hvn_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic vertex_t vtx(input longint px, input longint py, input longint pz,
                                  input longint nx, input longint ny, input longint nz,
                                  input logic err);
    vertex_t v;
    v.px = hvn_pkg::POS_W'(px);
    v.py = hvn_pkg::Y_W'(py);
    v.pz = hvn_pkg::POS_W'(pz);
    v.nx = hvn_pkg::NRM_W'(nx);
    v.ny = hvn_pkg::NY_W'(ny);
    v.nz = hvn_pkg::NRM_W'(nz);
    v.err = err;
    return v;
  endfunction

  function automatic step_t item_step(input logic fn, input int c, input int r, input int s);
    step_t st;
    st = '0;
    st.kind = STEP_ITEM;
    st.fn = fn;
    st.c = hvn_pkg::IDX_W'(c);
    st.r = hvn_pkg::IDX_W'(r);
    st.value = s;
    return st;
  endfunction

  function automatic step_t checked_step(input int c, input int r, input vertex_t want);
    step_t st;
    st = item_step(hvn_pkg::FUNC_QUERY, c, r, 0);
    st.typed = 1'b1;
    st.want = want;
    return st;
  endfunction

  function automatic step_t cfg_step(input logic [hvn_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [hvn_pkg::CFG_DATA_W-1:0] data);
    step_t st;
    st = '0;
    st.kind = STEP_CFG;
    st.reg_idx = idx;
    st.value = data;
    return st;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [hvn_pkg::SAMPLE_W-1:0] pick_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return hvn_pkg::SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_origin(input int n, input int ws);
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return 0;
    if (p == 1) return n - ws;
    return $urandom_range(0, n - ws);
  endfunction

  function automatic int near_window(input int w, input int ws, input int n);
    int v;
    v = w - 1 + $urandom_range(0, ws + 1);
    if (v < 0) v = 0;
    if (v > n - 1) v = n - 1;
    return v;
  endfunction

  task automatic send_item(input logic fn, input int c, input int r,
                           input logic [hvn_pkg::SAMPLE_W-1:0] s, input bit typed,
                           input vertex_t want);
    int gap;
    vertex_t v;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    func = fn;
    col = hvn_pkg::IDX_W'(c);
    row = hvn_pkg::IDX_W'(r);
    height_sample = s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n_items++;
    if (fn == hvn_pkg::FUNC_QUERY) begin
      v = typed ? want : predict_vertex(c, r);
      pending_vertices.push_back(v);
      n_queries++;
      if (v.err) n_off_map++;
    end else begin
      store_sample(c, r, s);
    end
  endtask

  task automatic drain_results();
    int guard;
    @(negedge clk);
    item_valid = 1'b0;
    guard = 0;
    while (pending_vertices.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hvn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hvn_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    n_reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure_phase(input int phase);
    int sel;
    logic [hvn_pkg::MSIZE_W-1:0] msz;
    logic [hvn_pkg::TILE_W-1:0]  tile;
    logic [hvn_pkg::HALF_W-1:0]  half;
    logic [hvn_pkg::SCALE_W-1:0] scale;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4: msz = hvn_pkg::MSIZE_W'($urandom_range(2, 12));
      5: msz = hvn_pkg::MSIZE_W'($urandom_range(0, 1));
      6: msz = hvn_pkg::MSIZE_W'(MAP_MAX);
      7: msz = hvn_pkg::MSIZE_W'($urandom_range(257, 511));
      8: msz = hvn_pkg::MSIZE_W'($urandom_range(13, 255));
      default: msz = 9'd2;
    endcase
    sel = $urandom_range(0, 7);
    tile = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd1 : (sel == 2) ? 16'hFFFF :
           hvn_pkg::TILE_W'($urandom_range(1, 65535));
    sel = $urandom_range(0, 5);
    half = (sel == 0) ? 26'd0 : (sel == 1) ? 26'h3FF_FFFF :
           (sel == 2) ? hvn_pkg::HALF_W'($urandom) :
           hvn_pkg::HALF_W'($urandom_range(0, 1 << 20));
    sel = $urandom_range(0, 5);
    scale = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : (sel == 2) ? 16'd256 :
            hvn_pkg::SCALE_W'($urandom_range(0, 65535));
    if (phase == 0) begin
      msz = 9'd2;
      tile = 16'd1;
      half = '0;
      scale = '0;
    end
    if (phase == 1) begin
      msz = hvn_pkg::MSIZE_W'(MAP_MAX);
      tile = '1;
      half = '1;
      scale = '1;
    end
    write_reg(hvn_pkg::CFG_MAP_SIZE, ($urandom << hvn_pkg::MSIZE_W) | msz);
    write_reg(hvn_pkg::CFG_TILE_SIZE, ($urandom << hvn_pkg::TILE_W) | tile);
    write_reg(hvn_pkg::CFG_HALF_EXTENT, ($urandom << hvn_pkg::HALF_W) | half);
    write_reg(hvn_pkg::CFG_HEIGHT_SCALE, ($urandom << hvn_pkg::SCALE_W) | scale);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(hvn_pkg::CFG_IDX_W'($urandom_range(int'(hvn_pkg::CFG_HEIGHT_SCALE) + 1, 255)),
                $urandom);
    end
  endtask

  task automatic run_phase(input int count);
    int n, ws, wc, wr, i, j, sent, pick, tries, c, r;
    bit found;
    n = active_side();
    ws = $urandom_range(3, 6);
    if (ws > n) ws = n;
    wc = pick_origin(n, ws);
    wr = pick_origin(n, ws);
    sent = 0;
    for (i = 0; i < ws; i++) begin
      for (j = 0; j < ws; j++) begin
        send_item(hvn_pkg::FUNC_WRITE, wc + j, wr + i, pick_sample(), 1'b0, '0);
        sent++;
      end
    end
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      found = 1'b0;
      c = 0;
      r = 0;
      if (pick < 65) begin
        for (tries = 0; tries < 8 && !found; tries++) begin
          c = near_window(wc, ws, n);
          r = near_window(wr, ws, n);
          found = heights_known(c, r);
        end
        if (found) send_item(hvn_pkg::FUNC_QUERY, c, r, hvn_pkg::SAMPLE_W'($urandom), 1'b0, '0);
        else send_item(hvn_pkg::FUNC_WRITE, near_window(wc, ws, n), near_window(wr, ws, n),
                       pick_sample(), 1'b0, '0);
      end else if (pick < 88) begin
        send_item(hvn_pkg::FUNC_WRITE, near_window(wc, ws, n), near_window(wr, ws, n),
                  pick_sample(), 1'b0, '0);
      end else if (pick < 97 && n < MAP_MAX) begin
        if ($urandom_range(0, 1) == 1) begin
          c = $urandom_range(n, 255);
          r = $urandom_range(0, 255);
        end else begin
          c = $urandom_range(0, 255);
          r = $urandom_range(n, 255);
        end
        send_item(($urandom_range(0, 1) == 1) ? hvn_pkg::FUNC_QUERY : hvn_pkg::FUNC_WRITE, c, r,
                  hvn_pkg::SAMPLE_W'($urandom), 1'b0, '0);
      end else begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        if (heights_known(c, r)) begin
          send_item(hvn_pkg::FUNC_QUERY, c, r, hvn_pkg::SAMPLE_W'($urandom), 1'b0, '0);
        end else begin
          send_item(hvn_pkg::FUNC_WRITE, c, r, pick_sample(), 1'b0, '0);
        end
      end
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_vertex = {pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, range_error};
      if (pending_vertices.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) $display("result beat with no vertex pending at %0t", $time);
      end else begin
        due_vertex = pending_vertices.pop_front();
        n_results++;
        if (seen_vertex !== due_vertex) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("vertex mismatch at %0t: expected pos %0d %0d %0d normal %0d %0d %0d err %0b",
                     $time, due_vertex.px, due_vertex.py, due_vertex.pz, due_vertex.nx,
                     due_vertex.ny, due_vertex.nz, due_vertex.err);
            $display("                        got pos %0d %0d %0d normal %0d %0d %0d err %0b",
                     seen_vertex.px, seen_vertex.py, seen_vertex.pz, seen_vertex.nx,
                     seen_vertex.ny, seen_vertex.nz, seen_vertex.err);
          end
        end
      end
    end
  end

  initial begin : result_side
    int run_left;
    int pick;
    result_stall = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (calm) begin
        result_stall = 1'b0;
        run_left = $urandom_range(5, 20);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          result_stall = 1'b0;
          run_left = $urandom_range(0, 5);
        end else if (pick < 92) begin
          result_stall = 1'b1;
          run_left = $urandom_range(0, 3);
        end else begin
          result_stall = 1'b1;
          run_left = $urandom_range(10, 50);
        end
      end
    end
  end

  initial begin
    #(HALF_PERIOD * 2 * 1000000);
    $display("run timed out with %0d vertices still pending", pending_vertices.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    int phase;
    rst = 1'b1;
    item_valid = 1'b0;
    func = hvn_pkg::FUNC_WRITE;
    col = '0;
    row = '0;
    height_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = hvn_pkg::CFG_MAP_SIZE;
    cfg_data = '0;

    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 0, 0, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 1, 0, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 0, 1, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 1, 1, 0));
    directed_plan.push_back(checked_step(0, 0, vtx(-32640, 0, -32640, 0, 65536, 0, 1'b0)));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 1, 1, 65535));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 0, 0, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 254, 254, 65535));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 255, 254, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 254, 255, 12345));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 255, 255, 65535));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 255, 255, 65535));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_MAP_SIZE, 4));
    directed_plan.push_back(checked_step(5, 5, vtx(0, 0, 0, 0, 0, 0, 1'b1)));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_WRITE, 7, 200, 777));
    directed_plan.push_back(checked_step(200, 7, vtx(0, 0, 0, 0, 0, 0, 1'b1)));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_MAP_SIZE, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 1, 1, 0));
    directed_plan.push_back(checked_step(2, 0, vtx(0, 0, 0, 0, 0, 0, 1'b1)));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_MAP_SIZE, 32'hFFFF_FFFF));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 255, 255, 0));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_TILE_SIZE, 0));
    directed_plan.push_back(checked_step(0, 0, vtx(-32640, 0, -32640, 0, 0, 0, 1'b0)));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_TILE_SIZE, 65535));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_HALF_EXTENT, 32'h03FF_FFFF));
    directed_plan.push_back(cfg_step(hvn_pkg::CFG_HEIGHT_SCALE, 65535));
    directed_plan.push_back(cfg_step(CFG_UNMAPPED, 32'hFFFF_FFFF));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 255, 255, 0));
    directed_plan.push_back(item_step(hvn_pkg::FUNC_QUERY, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < directed_plan.size(); i++) begin
      if (directed_plan[i].kind == STEP_CFG) begin
        drain_results();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        send_item(directed_plan[i].fn, int'(directed_plan[i].c), int'(directed_plan[i].r),
                  directed_plan[i].value[hvn_pkg::SAMPLE_W-1:0], directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      calm = (phase % 4 == 2) || (phase == 3);
      configure_phase(phase);
      // hold the result side so the core backs up into its input
      if (phase == 3) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    faults += pending_vertices.size();
    $display("Covered %0d items (%0d vertex queries, %0d off the map) with %0d register writes;",
             n_items, n_queries, n_off_map, n_reg_writes);
    $display("%0d result beats checked over %0d random phases, %0d faults.",
             n_results, NUM_PHASES, faults);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
